FILE: sv/pidl_pkg.sv
// Shared types, constants and command struct for the positional insert/delete list.
package pidl_pkg;

  // List depth and derived widths
  localparam int DEPTH = 64;
  localparam int WORD_W = 32;
  localparam int POS_W = 7;
  localparam int ENT_W = 7;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [ENT_W-1:0] ent_t;
  typedef logic [1:0] func_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CMP_W-1:0] cmp_t;

  // Operation codes
  localparam func_t OP_INSERT = 2'd0;
  localparam func_t OP_DELETE = 2'd1;
  localparam func_t OP_READ = 2'd2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    cmp_t pos;
  } cell_cmd_t;

endpackage

FILE: sv/pidl_in_if.sv
// Input channel: operation, position and word with valid/ready.
interface pidl_in_if;
  import pidl_pkg::*;

  logic valid;
  logic ready;
  func_t func;
  pos_t position;
  word_t value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink (input valid, input func, input position, input value, output ready);
endinterface

FILE: sv/pidl_out_if.sv
// Result channel: read word, entry count and status with valid/ready.
interface pidl_out_if;
  import pidl_pkg::*;

  logic valid;
  logic ready;
  word_t read_value;
  ent_t entry_count;
  status_t status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink (input valid, input read_value, input entry_count, input status,
                output ready);
endinterface

FILE: sv/pidl_cell.sv
// One list slot: holds a word and shifts it to or from its neighbors.
module pidl_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  pidl_pkg::cmp_t     idx,
  input  pidl_pkg::cell_cmd_t cmd,
  input  pidl_pkg::word_t    value,
  input  pidl_pkg::word_t    left_word,
  input  pidl_pkg::word_t    right_word,
  output pidl_pkg::word_t    word,
  output pidl_pkg::word_t    sel_word
);
  import pidl_pkg::*;

  word_t word_r;
  word_t word_nxt;

  // Pick the next word: shift up on insert (the addressed slot loads the new word), shift down on delete, else hold
  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (idx > cmd.pos) begin
        word_nxt = left_word;
      end else if (idx == cmd.pos) begin
        word_nxt = value;
      end
    end else if (cmd.del) begin
      if (idx >= cmd.pos) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;
  // Drive the read bus only when this slot is addressed
  assign sel_word = (idx == cmd.pos) ? word_r : '0;

endmodule

FILE: sv/pidl_ctrl.sv
// Entry counter and operation decode: status, shift command and next count.
module pidl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  pidl_pkg::func_t     func,
  input  pidl_pkg::pos_t      position,
  output pidl_pkg::cell_cmd_t cmd,
  output pidl_pkg::status_t   status,
  output logic                rd_ok,
  output pidl_pkg::cnt_t      count_nxt
);
  import pidl_pkg::*;

  cnt_t count_r;
  cmp_t cnt_ext;
  cmp_t pos_ext;

  assign cnt_ext = CMP_W'(count_r);
  assign pos_ext = CMP_W'(position);

  // Decode the operation against the current count
  always_comb begin
    cmd.ins = 1'b0;
    cmd.del = 1'b0;
    cmd.pos = pos_ext;
    status = ST_OK;
    rd_ok = 1'b0;
    count_nxt = count_r;
    case (func)
      OP_INSERT: begin
        if (count_r == CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          cmd.ins = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          cmd.del = accept;
          rd_ok = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Advance the count on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: sv/positional_insert_delete_list.sv
// Top level: ordered word list held in a chain of cells, with result register.
//
// Usage:
//   in_ch carries one operation per transaction: func (insert, delete, read),
//   a zero-based position and, for insert, the word to store. out_ch returns
//   exactly one result per operation: the word read or removed, the entry
//   count after the operation and a status (ok, full, empty, out of range).
//   A failed operation leaves the list untouched.
//   Latency: the result is valid the cycle after the input transaction.
//   Throughput: one operation per cycle; every cell shifts in parallel, and
//   the read word comes from a one-hot select across all cells.
//   A result that the receiver has not taken holds in the output register;
//   a new input is taken in the same cycle the held result is taken, and
//   in_ch.ready stays low while the held result is stalled.
//   Reset (rst_n low, synchronous) empties the list, clears every cell to
//   zero and drops any pending result.
module positional_insert_delete_list (
  input  logic        clk,
  input  logic        rst_n,
  pidl_in_if.sink     in_ch,
  pidl_out_if.source  out_ch
);
  import pidl_pkg::*;

  logic accept;
  cell_cmd_t cmd;
  status_t status;
  logic rd_ok;
  cnt_t count_nxt;
  cmp_t cnt_nxt_ext;
  word_t words [DEPTH];
  word_t sels [DEPTH];
  word_t rd_word;

  logic out_valid_r;
  word_t read_value_r;
  ent_t entry_count_r;
  status_t status_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  pidl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_ch.func),
    .position  (in_ch.position),
    .cmd       (cmd),
    .status    (status),
    .rd_ok     (rd_ok),
    .count_nxt (count_nxt)
  );

  // Chain of cells, each wired to its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end
    pidl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .idx        (CMP_W'(g)),
      .cmd        (cmd),
      .value      (in_ch.value),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[g]),
      .sel_word   (sels[g])
    );
  end

  // Merge the one-hot read bus
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | sels[i];
    end
  end

  assign cnt_nxt_ext = CMP_W'(count_nxt);

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_r <= rd_ok ? rd_word : '0;
      entry_count_r <= cnt_nxt_ext[ENT_W-1:0];
      status_r <= status;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.read_value = read_value_r;
  assign out_ch.entry_count = entry_count_r;
  assign out_ch.status = status_r;

endmodule

FILE: test/tb_positional_insert_delete_list.sv
// Testbench for the positional insert/delete list: random and directed ops, checked per result.
`timescale 1ns / 100ps

module tb_positional_insert_delete_list;
  import pidl_pkg::*;

  // Code the block treats as no operation
  localparam func_t OP_UNUSED = 2'd3;

  // Mixes of operations for the random part
  localparam int PLAN_FILL = 0;
  localparam int PLAN_MIXED = 1;
  localparam int PLAN_DRAIN = 2;

  // Idle behavior of either side
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SPARSE = 1;
  localparam int IDLE_BUSY = 2;

  localparam int RANDOM_BLOCKS = 6;
  localparam int BLOCK_OPS = 125;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 250000;

  typedef struct packed {
    func_t func;
    pos_t position;
    word_t value;
  } list_op_t;

  typedef struct packed {
    word_t read_value;
    ent_t entry_count;
    status_t status;
  } list_result_t;

  typedef struct packed {
    logic [DEPTH-1:0][WORD_W-1:0] cells;
    int count;
  } list_state_t;

  logic clk;
  logic rst_n;

  pidl_in_if in_ch ();
  pidl_out_if out_ch ();

  positional_insert_delete_list u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_op_t pending_ops[$];
  list_result_t expected_results[$];
  list_state_t list_now;
  list_state_t list_planned;
  list_op_t cur_op;
  int ops_queued;
  int ops_taken;
  int err_count;
  int cycle_count;
  int send_wait;
  int send_mode;
  int send_mode_left;
  int take_wait;
  int take_mode;
  int take_mode_left;

  // Apply one operation to a list and return the result it gives
  function automatic list_result_t apply_list_op(inout list_state_t s, input list_op_t op);
    list_result_t r;
    int i;
    int p;
    r.read_value = '0;
    r.status = ST_OK;
    p = int'(op.position);
    case (op.func)
      OP_INSERT: begin
        if (s.count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p > s.count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = s.count; i > p; i--) s.cells[i] = s.cells[i-1];
          s.cells[p] = op.value;
          s.count++;
        end
      end
      OP_DELETE: begin
        if (s.count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= s.count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = word_t'(s.cells[p]);
          for (i = p; i + 1 < s.count; i++) s.cells[i] = s.cells[i+1];
          s.cells[s.count-1] = '0;
          s.count--;
        end
      end
      OP_READ: begin
        if (s.count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= s.count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = word_t'(s.cells[p]);
        end
      end
      default: begin
      end
    endcase
    r.entry_count = ent_t'(s.count);
    return r;
  endfunction

  function automatic int draw_wait(input int mode);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_SPARSE) return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Queue one operation; track the list as it will stand once it is taken
  task automatic queue_op(input func_t f, input int p, input word_t v);
    list_op_t op;
    op.func = f;
    op.position = pos_t'(p);
    op.value = v;
    void'(apply_list_op(list_planned, op));
    pending_ops.push_back(op);
    ops_queued++;
  endtask

  task automatic queue_random_op(input int plan);
    int roll;
    int cnt;
    int ins_pct;
    int del_pct;
    int p;
    func_t f;
    cnt = list_planned.count;
    ins_pct = (plan == PLAN_FILL) ? 85 : (plan == PLAN_MIXED) ? 40 : 5;
    del_pct = (plan == PLAN_FILL) ? 5 : (plan == PLAN_DRAIN) ? 85 : 35;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) f = OP_INSERT;
    else if (roll < ins_pct + del_pct) f = OP_DELETE;
    else f = OP_READ;
    if ($urandom_range(0, 49) == 0) f = OP_UNUSED;
    // Mostly legal positions, some anywhere in the field
    if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 127);
    else if (f == OP_INSERT) p = $urandom_range(0, cnt);
    else p = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
    queue_op(f, p, rand_word());
  endtask

  // Hold until every queued transaction has been taken and answered
  task automatic wait_drained();
    while (ops_taken != ops_queued || expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive input transactions from the pending queue
  always @(posedge clk) begin : drive_ops
    logic nxt_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_wait = 0;
      send_mode_left = 0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_list_op(list_now, cur_op));
        ops_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          in_ch.func <= cur_op.func;
          in_ch.position <= cur_op.position;
          in_ch.value <= cur_op.value;
          nxt_valid = 1'b1;
          if (send_mode_left == 0) begin
            send_mode = $urandom_range(IDLE_NONE, IDLE_BUSY);
            send_mode_left = 32;
          end
          send_mode_left--;
          send_wait = draw_wait(send_mode);
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // Take results, stall at random and compare against the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    logic nxt_ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_wait = 0;
      take_mode_left = 0;
    end else begin
      nxt_ready = out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no operation outstanding");
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_ch.read_value);
            err_count++;
          end
          if (out_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_ch.entry_count);
            err_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            err_count++;
          end
        end
        if (take_mode_left == 0) begin
          take_mode = $urandom_range(IDLE_NONE, IDLE_BUSY);
          take_mode_left = 32;
        end
        take_mode_left--;
        take_wait = draw_wait(take_mode);
        nxt_ready = (take_wait == 0);
      end else if (!out_ch.ready) begin
        if (take_wait > 0) take_wait--;
        nxt_ready = (take_wait == 0);
      end
      out_ch.ready <= nxt_ready;
    end
  end

  // Stimulus and end of run
  initial begin
    int b;
    int n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = OP_INSERT;
    in_ch.position = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    list_now = '0;
    list_planned = '0;
    ops_queued = 0;
    ops_taken = 0;
    err_count = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: empty wins over a bad position
    queue_op(OP_READ, 0, '0);
    queue_op(OP_DELETE, 0, '0);
    queue_op(OP_READ, 127, '0);
    queue_op(OP_DELETE, 127, '0);
    // Insert past the end
    queue_op(OP_INSERT, 1, 32'sd5);
    queue_op(OP_INSERT, 127, -32'sd1);
    // Build at start, end and middle with extreme words
    queue_op(OP_INSERT, 0, 32'sh7fff_ffff);
    queue_op(OP_INSERT, 1, 32'sh8000_0000);
    queue_op(OP_INSERT, 0, -32'sd1);
    queue_op(OP_INSERT, 1, '0);
    queue_op(OP_INSERT, 4, 32'sh5a5a_a5a5);
    queue_op(OP_INSERT, 6, 32'sd7);
    for (n = 0; n < 5; n++) queue_op(OP_READ, n, '0);
    queue_op(OP_READ, 5, '0);
    queue_op(OP_READ, 127, '0);
    // Remove at end, start and middle; then past the end
    queue_op(OP_DELETE, 4, '0);
    queue_op(OP_DELETE, 0, '0);
    queue_op(OP_DELETE, 1, '0);
    queue_op(OP_DELETE, 3, '0);
    // Unused code changes nothing
    queue_op(OP_UNUSED, 127, -32'sd1);
    wait_drained();

    // Random blocks: insert-heavy fill, mixed churn, delete-heavy drain
    for (b = 0; b < RANDOM_BLOCKS; b++) begin
      for (n = 0; n < BLOCK_OPS; n++) queue_random_op(b % 3);
      if (b % 2 == 1) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
